/* hdl/patm_pkg.sv */
package patm_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int COEF_W        = 16;
  localparam int SUM_W         = 17;
  localparam int PROD_W        = 36;
  localparam int MUL_W         = 2 * COEF_W;
  localparam int DEG_W         = 4;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;
  localparam int REG_DEGREE    = 0;
  localparam logic [DEG_W-1:0] DEGREE_RST = 4'd15;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic first;
    logic lastk;
    logic load_out;
    logic out_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/patm_ram.sv */
module patm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/patm_ctl.sv */
module patm_ctl #(
  parameter int MAX_TERMS = patm_pkg::MAX_TERMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cfg_clear,
  input  logic [$clog2(MAX_TERMS)-1:0] last_idx,
  input  patm_pkg::dp_status_t         status,
  output patm_pkg::ctl_cmd_t           cmd,
  output logic [$clog2(MAX_TERMS)-1:0] wr_addr,
  output logic [$clog2(MAX_TERMS)-1:0] rd_addr_a,
  output logic [$clog2(MAX_TERMS)-1:0] rd_addr_b,
  output logic [$clog2(MAX_TERMS)-1:0] k_idx
);
  import patm_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);

  typedef enum logic [4:0] {
    S_LOAD   = 5'b00001,
    S_MAC    = 5'b00010,
    S_DRAIN1 = 5'b00100,
    S_DRAIN2 = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] load_count, load_count_next;
  logic [AW-1:0] k, k_next;
  logic [AW-1:0] i, i_next;
  logic          in_acc;

  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign wr_addr   = load_count;
  assign rd_addr_a = i;
  assign rd_addr_b = k - i;
  assign k_idx     = k;

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    k_next          = k;
    i_next          = i;
    cmd             = '0;
    unique case (state)
      S_LOAD: begin
        if (in_acc) begin
          cmd.wr_en = 1'b1;
          if (load_count == last_idx) begin
            load_count_next = '0;
            k_next          = '0;
            i_next          = '0;
            state_next      = S_MAC;
          end else begin
            load_count_next = load_count + 1'b1;
          end
        end
      end
      S_MAC: begin
        cmd.rd_en = 1'b1;
        cmd.first = (i == '0);
        cmd.lastk = (i == k);
        if (i == k) begin
          state_next = S_DRAIN1;
        end else begin
          i_next = i + 1'b1;
        end
      end
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_EMIT;
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_last = (k == last_idx);
          if (k == last_idx) begin
            state_next = S_LOAD;
          end else begin
            k_next     = k + 1'b1;
            i_next     = '0;
            state_next = S_MAC;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
    if (cfg_clear) begin
      load_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      k          <= '0;
      i          <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      k          <= k_next;
      i          <= i_next;
    end
  end

endmodule

/* hdl/patm_dp.sv */
module patm_dp #(
  parameter int MAX_TERMS = patm_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [patm_pkg::COEF_W-1:0]  coef_a,
  input  logic signed [patm_pkg::COEF_W-1:0]  coef_b,
  input  patm_pkg::ctl_cmd_t                  cmd,
  output patm_pkg::dp_status_t                status,
  input  logic [$clog2(MAX_TERMS)-1:0]        wr_addr,
  input  logic [$clog2(MAX_TERMS)-1:0]        rd_addr_a,
  input  logic [$clog2(MAX_TERMS)-1:0]        rd_addr_b,
  input  logic [$clog2(MAX_TERMS)-1:0]        k_idx,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [patm_pkg::DEG_W-1:0]          term_degree,
  output logic signed [patm_pkg::SUM_W-1:0]   sum_coef,
  output logic signed [patm_pkg::PROD_W-1:0]  prod_coef,
  output logic                                last
);
  import patm_pkg::*;

  logic [COEF_W-1:0]        rd_a, rd_b;
  logic                     rd_valid, rd_first, rd_lastk;
  logic signed [COEF_W-1:0] ak, bk;
  logic signed [MUL_W-1:0]  prod;
  logic                     prod_valid;
  logic signed [PROD_W-1:0] acc;

  patm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (coef_a),
    .raddr (rd_addr_a),
    .rdata (rd_a)
  );

  patm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (coef_b),
    .raddr (rd_addr_b),
    .rdata (rd_b)
  );

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid   <= cmd.rd_en;
      prod_valid <= rd_valid;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_first <= cmd.first;
    rd_lastk <= cmd.lastk;
    if (rd_valid && rd_first) begin
      bk <= $signed(rd_b);
    end
    if (rd_valid && rd_lastk) begin
      ak <= $signed(rd_a);
    end
    prod <= $signed(rd_a) * $signed(rd_b);
    if (cmd.rd_en && cmd.first) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + PROD_W'(prod);
    end
    if (cmd.load_out) begin
      term_degree <= DEG_W'(k_idx);
      sum_coef    <= SUM_W'(ak) + SUM_W'(bk);
      prod_coef   <= acc;
      last        <= cmd.out_last;
    end
  end

endmodule

/* hdl/polynomial_add_and_truncated_multiply.sv */
// Results: after the last pair of a set is accepted, each result k is computed in turn
//   by reading a[i] and b[k - i] for i = 0 to k, passing the S_DRAIN1 and S_DRAIN2
//   states and loading the output register, which waits while the output is stalled.
// One set of n = degree + 1 terms at a time; input stalls from the end of its load until
//   its final term is issued. One multiply-accumulate unit, one read port per store.
// Reset (rst, synchronous): degree = 15, load count cleared, stores not cleared.
module polynomial_add_and_truncated_multiply #(
  parameter int MAX_TERMS = patm_pkg::MAX_TERMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [patm_pkg::PADDR_W-1:0]        paddr,
  input  logic [patm_pkg::PDATA_W-1:0]        pwdata,
  output logic [patm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [patm_pkg::COEF_W-1:0]  coef_a,
  input  logic signed [patm_pkg::COEF_W-1:0]  coef_b,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [patm_pkg::DEG_W-1:0]          term_degree,
  output logic signed [patm_pkg::SUM_W-1:0]   sum_coef,
  output logic signed [patm_pkg::PROD_W-1:0]  prod_coef,
  output logic                                last
);
  import patm_pkg::*;

  localparam int AW      = $clog2(MAX_TERMS);
  localparam int LastMax = MAX_TERMS - 1;

  logic [DEG_W-1:0] degree;
  logic             deg_sel, deg_wr;
  logic [AW-1:0]    last_idx;
  logic [AW-1:0]    wr_addr, rd_addr_a, rd_addr_b, k_idx;
  ctl_cmd_t         cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign deg_sel = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_DEGREE));
  assign deg_wr  = psel && penable && pwrite && pready && deg_sel;
  assign prdata  = deg_sel ? PDATA_W'(degree) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEGREE_RST;
    end else if (deg_wr) begin
      degree <= pwdata[DEG_W-1:0];
    end
  end

  always_comb begin
    if (32'(degree) > LastMax) begin
      last_idx = AW'(LastMax);
    end else begin
      last_idx = AW'(degree);
    end
  end

  patm_ctl #(.MAX_TERMS(MAX_TERMS)) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_clear (deg_wr),
    .last_idx  (last_idx),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .k_idx     (k_idx)
  );

  patm_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .coef_a      (coef_a),
    .coef_b      (coef_b),
    .cmd         (cmd),
    .status      (status),
    .wr_addr     (wr_addr),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .k_idx       (k_idx),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .term_degree (term_degree),
    .sum_coef    (sum_coef),
    .prod_coef   (prod_coef),
    .last        (last)
  );

  // stall rises only on the request that completes a set
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without a completing request");

  // loading resumes only once the final term is in the output register
  a_stall_fall: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(in_stall) |-> out_valid && last)
    else $error("input reopened before final term was issued");

  a_mid_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("non-final term pending while accepting input");

endmodule

/* test/polynomial_add_and_truncated_multiply_tb.sv */
`timescale 1ns / 100ps

module polynomial_add_and_truncated_multiply_tb;
  import patm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 380;

  typedef struct {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
  } coef_pair_t;

  typedef struct {
    logic [DEG_W-1:0] deg;
    logic signed [SUM_W-1:0] sum;
    logic signed [PROD_W-1:0] prod;
    logic last;
  } term_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COEF_W-1:0] coef_a = '0;
  logic signed [COEF_W-1:0] coef_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DEG_W-1:0] term_degree;
  logic signed [SUM_W-1:0] sum_coef;
  logic signed [PROD_W-1:0] prod_coef;
  logic last;

  coef_pair_t pair_q[$];
  term_t term_q[$];

  logic [DEG_W-1:0] deg_cfg = DEGREE_RST;
  int load_cnt = 0;
  logic signed [COEF_W-1:0] store_a[MAX_TERMS_DEF];
  logic signed [COEF_W-1:0] store_b[MAX_TERMS_DEF];

  logic in_took = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_id = 0;
  int hold_seen = 0;
  bit in_idle_on = 1'b0;
  bit out_idle_on = 1'b0;
  int errors = 0;
  int cycle_cnt = 0;

  polynomial_add_and_truncated_multiply DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .coef_a(coef_a),
    .coef_b(coef_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .term_degree(term_degree),
    .sum_coef(sum_coef),
    .prod_coef(prod_coef),
    .last(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return COEF_W'($urandom_range(0, 511)) - COEF_W'(256);
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // sum and truncated product of the stored operands, one term per degree
  task automatic load_pair(input coef_pair_t p);
    int n;
    longint acc;
    term_t t;
    n = int'(deg_cfg) + 1;
    if (n > MAX_TERMS_DEF) n = MAX_TERMS_DEF;
    if (load_cnt >= n) load_cnt = 0;
    store_a[load_cnt] = p.a;
    store_b[load_cnt] = p.b;
    load_cnt++;
    if (load_cnt < n) return;
    load_cnt = 0;
    for (int k = 0; k < n; k++) begin
      acc = 0;
      for (int i = 0; i <= k; i++) acc += longint'(store_a[i]) * longint'(store_b[k - i]);
      t.deg = DEG_W'(k);
      t.sum = SUM_W'(longint'(store_a[k]) + longint'(store_b[k]));
      t.prod = PROD_W'(acc);
      t.last = (k == n - 1);
      term_q.push_back(t);
    end
  endtask

  always @(negedge clk) begin : request_driver
    coef_pair_t p;
    if (!rst && (!in_valid || in_took)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pair_q.size() != 0) begin
        p = pair_q.pop_front();
        coef_a <= p.a;
        coef_b <= p.b;
        in_valid <= 1'b1;
        in_gap <= (in_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_id != hold_seen) begin
      hold_seen <= hold_id;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    term_t want;
    in_took <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) load_pair('{coef_a, coef_b});
    if (!rst && out_valid && !out_stall) begin
      if (term_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: degree %0d sum %0d prod %0d last %0b",
                   term_degree, sum_coef, prod_coef, last);
      end else begin
        want = term_q.pop_front();
        if (term_degree !== want.deg || sum_coef !== want.sum ||
            prod_coef !== want.prod || last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp deg %0d sum %0d prod %0d last %0b, got %0d %0d %0d %0b",
                     want.deg, want.sum, want.prod, want.last,
                     term_degree, sum_coef, prod_coef, last);
        end
      end
    end
  end

  task automatic write_degree(input int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_DEGREE * 4);
    pwdata <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    deg_cfg = DEG_W'(value);
    load_cnt = 0;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    while (pair_q.size() != 0 || in_valid || term_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pair(input logic signed [COEF_W-1:0] a,
                           input logic signed [COEF_W-1:0] b);
    coef_pair_t p;
    p.a = a;
    p.b = b;
    pair_q.push_back(p);
  endtask

  // full sets of random pairs, optionally followed by a partial set
  task automatic run_phase(input int deg, input int sets, input int tail,
                           input bit in_idle, input bit out_idle, input bit hold);
    write_degree(deg);
    in_idle_on = in_idle;
    out_idle_on = out_idle;
    if (hold) begin
      @(posedge clk);
      hold_id = hold_id + 1;
    end
    repeat (sets * (deg + 1) + tail) push_pair(rand_coef(), rand_coef());
    settle();
  endtask

  initial begin
    int deg;
    int sets;
    int tail;
    int sent;
    int phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset degree, all-negative operands give the largest products
    repeat (16) push_pair(16'sh8000, 16'sh8000);
    settle();

    // constant polynomials, one result per request
    write_degree(0);
    push_pair(16'sh7fff, 16'sh7fff);
    push_pair(16'sh8000, 16'sh8000);
    push_pair(16'sh8000, 16'sh7fff);
    push_pair(16'sh0000, 16'sh0000);
    settle();

    // partial load abandoned by a degree write
    write_degree(3);
    push_pair(16'sh1234, 16'shedcb);
    push_pair(16'sh7fff, 16'sh8000);
    settle();
    write_degree(2);
    push_pair(16'sh7fff, 16'sh8000);
    push_pair(16'sh8000, 16'sh7fff);
    push_pair(16'sh0100, 16'shff00);
    settle();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        deg = 1;
      end else begin
        case ($urandom_range(0, 7))
          0: deg = 0;
          1: deg = 15;
          default: deg = $urandom_range(1, 6);
        endcase
      end
      if (phase == 2) begin
        run_phase(15, 3, 0, 1'b0, 1'b0, 1'b1);
        sent += 48;
      end else begin
        if (deg == 15) sets = 1;
        else if (deg == 0) sets = $urandom_range(4, 12);
        else sets = $urandom_range(1, 4);
        tail = (deg > 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, deg) : 0;
        run_phase(deg, sets, tail, $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
        sent += sets * (deg + 1) + tail;
      end
      phase++;
    end

    settle();
    if (errors == 0 && term_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
